@@ rtl/psm_pkg.sv @@
// Shared types, register codes and constants of the position speed median check.
package psm_pkg;

  localparam int QDEPTH = 4;
  localparam int QAW    = 2;

  localparam logic [15:0] WRAP_TOP = 16'hFFFF;

  localparam logic [2:0] REG_SPEED_GAIN     = 3'd0;
  localparam logic [2:0] REG_WRAP_LIMIT     = 3'd1;
  localparam logic [2:0] REG_WRAP_HIGH_MARK = 3'd2;
  localparam logic [2:0] REG_SPEED_MIN      = 3'd3;
  localparam logic [2:0] REG_SPEED_MAX      = 3'd4;
  localparam logic [2:0] REG_WINDOW_START   = 3'd5;
  localparam logic [2:0] REG_WINDOW_END     = 3'd6;

  localparam logic [15:0] RST_SPEED_GAIN     = 16'd34133;
  localparam logic [18:0] RST_WRAP_LIMIT     = 19'd10000;
  localparam logic [15:0] RST_WRAP_HIGH_MARK = 16'd60000;
  localparam logic [18:0] RST_SPEED_MIN      = 19'd4500;
  localparam logic [18:0] RST_SPEED_MAX      = 19'd5500;
  localparam logic [12:0] RST_WINDOW_START   = 13'd300;
  localparam logic [12:0] RST_WINDOW_END     = 13'd320;

  localparam logic [1:0] ST_OUTSIDE = 2'd0;
  localparam logic [1:0] ST_OK      = 2'd1;
  localparam logic [1:0] ST_HIGH    = 2'd2;
  localparam logic [1:0] ST_LOW     = 2'd3;

  typedef struct packed {
    logic [15:0] speed_gain;
    logic [18:0] wrap_limit;
    logic [15:0] wrap_high_mark;
    logic [18:0] speed_min;
    logic [18:0] speed_max;
    logic [12:0] window_start;
    logic [12:0] window_end;
  } psm_cfg_t;

  // One classified sample as handed from front to back.
  typedef struct packed {
    logic [15:0] d_mag;
    logic        d_neg;
    logic [16:0] w_mag;
    logic        w_neg;
    logic        clear;
    logic        has_speed;
    logic        emit;
  } psm_entry_t;

endpackage

@@ rtl/psm_chan_if.sv @@
// Valid/ready channel interfaces for position samples and filtered results.
interface psm_in_if;
  logic        valid;
  logic        ready;
  logic [15:0] position;
  logic        start_of_run;

  modport source (output valid, output position, output start_of_run, input ready);
  modport sink   (input valid, input position, input start_of_run, output ready);
endinterface

interface psm_out_if;
  logic               valid;
  logic               ready;
  logic signed [19:0] filtered_speed;
  logic [12:0]        sample_index;
  logic [1:0]         check_status;
  logic               window_failed;

  modport source (output valid, output filtered_speed, output sample_index,
                  output check_status, output window_failed, input ready);
  modport sink   (input valid, input filtered_speed, input sample_index,
                  input check_status, input window_failed, output ready);
endinterface

@@ rtl/psm_cfg.sv @@
// APB-style configuration registers of the position speed median check.
module psm_cfg (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic [4:0]        cfg_paddr,
  input  logic [31:0]       cfg_pwdata,
  output logic [31:0]       cfg_prdata,
  output logic              cfg_pready,
  output psm_pkg::psm_cfg_t cfg
);

  psm_pkg::psm_cfg_t cfg_r;
  logic [2:0]        reg_idx;
  logic              wr_en;

  assign reg_idx    = cfg_paddr[4:2];
  assign cfg_pready = 1'b1;
  assign wr_en      = cfg_psel & cfg_penable & cfg_pwrite;
  assign cfg        = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.speed_gain     <= psm_pkg::RST_SPEED_GAIN;
      cfg_r.wrap_limit     <= psm_pkg::RST_WRAP_LIMIT;
      cfg_r.wrap_high_mark <= psm_pkg::RST_WRAP_HIGH_MARK;
      cfg_r.speed_min      <= psm_pkg::RST_SPEED_MIN;
      cfg_r.speed_max      <= psm_pkg::RST_SPEED_MAX;
      cfg_r.window_start   <= psm_pkg::RST_WINDOW_START;
      cfg_r.window_end     <= psm_pkg::RST_WINDOW_END;
    end else if (wr_en) begin
      case (reg_idx)
        psm_pkg::REG_SPEED_GAIN:     cfg_r.speed_gain     <= cfg_pwdata[15:0];
        psm_pkg::REG_WRAP_LIMIT:     cfg_r.wrap_limit     <= cfg_pwdata[18:0];
        psm_pkg::REG_WRAP_HIGH_MARK: cfg_r.wrap_high_mark <= cfg_pwdata[15:0];
        psm_pkg::REG_SPEED_MIN:      cfg_r.speed_min      <= cfg_pwdata[18:0];
        psm_pkg::REG_SPEED_MAX:      cfg_r.speed_max      <= cfg_pwdata[18:0];
        psm_pkg::REG_WINDOW_START:   cfg_r.window_start   <= cfg_pwdata[12:0];
        psm_pkg::REG_WINDOW_END:     cfg_r.window_end     <= cfg_pwdata[12:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      psm_pkg::REG_SPEED_GAIN:     cfg_prdata = {16'd0, cfg_r.speed_gain};
      psm_pkg::REG_WRAP_LIMIT:     cfg_prdata = {13'd0, cfg_r.wrap_limit};
      psm_pkg::REG_WRAP_HIGH_MARK: cfg_prdata = {16'd0, cfg_r.wrap_high_mark};
      psm_pkg::REG_SPEED_MIN:      cfg_prdata = {13'd0, cfg_r.speed_min};
      psm_pkg::REG_SPEED_MAX:      cfg_prdata = {13'd0, cfg_r.speed_max};
      psm_pkg::REG_WINDOW_START:   cfg_prdata = {19'd0, cfg_r.window_start};
      psm_pkg::REG_WINDOW_END:     cfg_prdata = {19'd0, cfg_r.window_end};
      default:                     cfg_prdata = 32'd0;
    endcase
  end

endmodule

@@ rtl/psm_front.sv @@
// Front end: accepts position samples, tracks run fill and forms both speed candidates.
module psm_front (
  input  logic                clk,
  input  logic                rst_n,
  input  psm_pkg::psm_cfg_t   cfg,
  input  logic                in_valid,
  input  logic [15:0]         in_position,
  input  logic                in_start_of_run,
  input  logic                q_full,
  output logic                in_ready,
  output logic                push,
  output psm_pkg::psm_entry_t entry
);

  logic [15:0] last_pos_r;
  logic [1:0]  fill_r;
  logic [1:0]  fill_eff;
  logic [1:0]  fill_nxt;
  logic [16:0] diff;
  logic        upward;

  assign in_ready = ~q_full;
  assign push     = in_valid & ~q_full;
  assign fill_eff = in_start_of_run ? 2'd0 : fill_r;

  always_comb begin
    diff   = {1'b0, in_position} - {1'b0, last_pos_r};
    upward = last_pos_r > cfg.wrap_high_mark;

    entry.d_neg = diff[16];
    entry.d_mag = diff[16] ? 16'(-diff) : diff[15:0];
    // Wrap through the top of the position range, direction set by the older sample.
    entry.w_mag = upward ? ({1'b0, in_position} + {1'b0, psm_pkg::WRAP_TOP - last_pos_r})
                         : ({1'b0, psm_pkg::WRAP_TOP - in_position} + {1'b0, last_pos_r});
    entry.w_neg     = ~upward;
    entry.clear     = in_start_of_run;
    entry.has_speed = fill_eff != 2'd0;
    entry.emit      = fill_eff == 2'd3;

    if (fill_eff == 2'd3) fill_nxt = 2'd3;
    else                  fill_nxt = fill_eff + 2'd1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_pos_r <= 16'd0;
      fill_r     <= 2'd0;
    end else if (push) begin
      last_pos_r <= in_position;
      fill_r     <= fill_nxt;
    end
  end

endmodule

@@ rtl/psm_queue.sv @@
// Short queue of classified samples between the front and back ends.
module psm_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  psm_pkg::psm_entry_t wr_entry,
  input  logic                pop,
  output logic                empty,
  output logic                full,
  output psm_pkg::psm_entry_t rd_entry
);

  psm_pkg::psm_entry_t mem_r [psm_pkg::QDEPTH];
  logic [psm_pkg::QAW-1:0] wr_ptr_r;
  logic [psm_pkg::QAW-1:0] rd_ptr_r;
  logic [psm_pkg::QAW:0]   count_r;

  assign empty    = count_r == '0;
  assign full     = count_r == (psm_pkg::QAW+1)'(psm_pkg::QDEPTH);
  assign rd_entry = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= wr_entry;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (pop)  rd_ptr_r <= rd_ptr_r + 1'b1;
      case ({push, pop})
        2'b10:   count_r <= count_r + 1'b1;
        2'b01:   count_r <= count_r - 1'b1;
        default: count_r <= count_r;
      endcase
    end
  end

endmodule

@@ rtl/psm_back.sv @@
// Back end: scales speeds, picks wrap handling, median filters and checks the window.
module psm_back #(
  parameter int MAX_SAMPLES = 8192
) (
  input  logic                clk,
  input  logic                rst_n,
  input  psm_pkg::psm_cfg_t   cfg,
  input  logic                q_empty,
  input  psm_pkg::psm_entry_t q_entry,
  output logic                pop,
  input  logic                out_ready,
  output logic                out_valid,
  output logic signed [19:0]  out_filtered_speed,
  output logic [12:0]         out_sample_index,
  output logic [1:0]          out_check_status,
  output logic                out_window_failed
);

  localparam int IdxCap = (MAX_SAMPLES - 1 > 8191) ? 8191 : MAX_SAMPLES - 1;

  logic adv;

  // stage A: products
  logic        a_vld_r;
  logic [31:0] a_p1_r;
  logic [32:0] a_p2_r;
  logic        a_d_neg_r, a_w_neg_r, a_clear_r, a_has_r, a_emit_r;

  // stage B: speed and median
  logic               b_vld_r;
  logic signed [19:0] b_med_r;
  logic               b_clear_r, b_emit_r;
  logic signed [19:0] hist0_r, hist1_r;
  logic [17:0]        m1;
  logic [18:0]        m2;
  logic [18:0]        mag;
  logic               neg;
  logic signed [19:0] speed;
  logic signed [19:0] lo, hi, mid, med;

  // stage C: check and output
  logic        out_vld_r;
  logic [12:0] run_index_r;
  logic        fail_r;
  logic [19:0] fmag;
  logic        in_win;
  logic [1:0]  status;

  assign adv = ~out_vld_r | out_ready;
  assign pop = adv & ~q_empty;

  always_ff @(posedge clk) begin
    if (adv) begin
      a_p1_r    <= 32'(q_entry.d_mag) * 32'(cfg.speed_gain);
      a_p2_r    <= 33'(q_entry.w_mag) * 33'(cfg.speed_gain);
      a_d_neg_r <= q_entry.d_neg;
      a_w_neg_r <= q_entry.w_neg;
      a_clear_r <= q_entry.clear;
      a_has_r   <= q_entry.has_speed;
      a_emit_r  <= q_entry.emit;
    end
  end

  always_comb begin
    m1  = a_p1_r[31:14];
    m2  = a_p2_r[32:14];
    // Recompute as a wrap when the plain speed is out of reach.
    if ({1'b0, m1} > cfg.wrap_limit) begin
      mag = m2;
      neg = a_w_neg_r;
    end else begin
      mag = {1'b0, m1};
      neg = a_d_neg_r;
    end
    // Sign is inverted on the way out.
    speed = neg ? $signed({1'b0, mag}) : -$signed({1'b0, mag});
    lo    = (hist0_r < hist1_r) ? hist0_r : hist1_r;
    hi    = (hist0_r < hist1_r) ? hist1_r : hist0_r;
    mid   = (hi < speed) ? hi : speed;
    med   = (lo > mid) ? lo : mid;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      b_med_r   <= med;
      b_clear_r <= a_clear_r;
      b_emit_r  <= a_emit_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hist0_r <= '0;
      hist1_r <= '0;
    end else if (adv && a_vld_r && a_has_r) begin
      hist0_r <= hist1_r;
      hist1_r <= speed;
    end
  end

  always_comb begin
    fmag   = b_med_r[19] ? 20'(-b_med_r) : 20'(b_med_r);
    in_win = (run_index_r >= cfg.window_start) && (run_index_r <= cfg.window_end);
    if (!in_win)                          status = psm_pkg::ST_OUTSIDE;
    else if (fmag > {1'b0, cfg.speed_max}) status = psm_pkg::ST_HIGH;
    else if (fmag < {1'b0, cfg.speed_min}) status = psm_pkg::ST_LOW;
    else                                  status = psm_pkg::ST_OK;
  end

  always_ff @(posedge clk) begin
    if (adv && b_vld_r && b_emit_r) begin
      out_filtered_speed <= b_med_r;
      out_sample_index   <= run_index_r;
      out_check_status   <= status;
      out_window_failed  <= fail_r | (status == psm_pkg::ST_HIGH) |
                            (status == psm_pkg::ST_LOW);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r     <= 1'b0;
      b_vld_r     <= 1'b0;
      out_vld_r   <= 1'b0;
      run_index_r <= '0;
      fail_r      <= 1'b0;
    end else if (adv) begin
      a_vld_r   <= ~q_empty;
      b_vld_r   <= a_vld_r;
      out_vld_r <= b_vld_r & b_emit_r;
      if (b_vld_r && b_clear_r) begin
        run_index_r <= '0;
        fail_r      <= 1'b0;
      end else if (b_vld_r && b_emit_r) begin
        if (status == psm_pkg::ST_HIGH || status == psm_pkg::ST_LOW) fail_r <= 1'b1;
        if (run_index_r < 13'(IdxCap)) run_index_r <= run_index_r + 13'd1;
      end
    end
  end

  assign out_valid = out_vld_r;

  a_idx_cap: assert property (@(posedge clk) disable iff (!rst_n)
    run_index_r <= 13'(IdxCap))
    else $error("run index beyond cap");

  a_fail_sticky_out: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && (out_check_status == psm_pkg::ST_HIGH ||
                  out_check_status == psm_pkg::ST_LOW) |-> out_window_failed)
    else $error("failed check without failure flag");

  a_checked_in_window: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && out_check_status != psm_pkg::ST_OUTSIDE |->
      out_sample_index >= cfg.window_start && out_sample_index <= cfg.window_end)
    else $error("checked index outside window");

  a_fail_holds: assert property (@(posedge clk) disable iff (!rst_n)
    fail_r && !(b_vld_r && b_clear_r && adv) |=> fail_r)
    else $error("failure flag dropped without start of run");

endmodule

@@ rtl/position_speed_median_check.sv @@
// Top level of the position speed median check: encoder speed, median of three, window check.
//
// Usage:
//   in_ch  (sink)   : rotor position samples with a start_of_run flag; a transfer takes
//                     place when valid and ready are high at a rising clock edge.
//   out_ch (source) : filtered speed, its index in the run, check status and the sticky
//                     window failure flag; one result per sample from the fourth of a run.
//   cfg_*           : APB-style register port, registers at byte address 4*i, pready tied
//                     high; write only while no sample is in flight.
// Throughput: one sample per cycle while out_ch is ready.
// Pipeline: a sample passes the queue, the gain multiply stage, the speed select and
//   median stage, then the check and output register.
// The first three samples of a run give no result.
// Reset (rst_n low, synchronous): registers return to defaults, history, index and the
//   failure flag clear, the queue empties.
// When out_ch stalls the whole back end holds; the 4-entry queue keeps taking samples
//   until it is full, then in_ch.ready drops.
module position_speed_median_check #(
  parameter int MAX_SAMPLES = 8192
) (
  input  logic        clk,
  input  logic        rst_n,
  psm_in_if.sink      in_ch,
  psm_out_if.source   out_ch,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [4:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  psm_pkg::psm_cfg_t   cfg;
  psm_pkg::psm_entry_t wr_entry;
  psm_pkg::psm_entry_t rd_entry;
  logic                push, pop, q_empty, q_full;

  psm_cfg u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .cfg         (cfg)
  );

  psm_front u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg             (cfg),
    .in_valid        (in_ch.valid),
    .in_position     (in_ch.position),
    .in_start_of_run (in_ch.start_of_run),
    .q_full          (q_full),
    .in_ready        (in_ch.ready),
    .push            (push),
    .entry           (wr_entry)
  );

  psm_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .wr_entry (wr_entry),
    .pop      (pop),
    .empty    (q_empty),
    .full     (q_full),
    .rd_entry (rd_entry)
  );

  psm_back #(
    .MAX_SAMPLES (MAX_SAMPLES)
  ) u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg                (cfg),
    .q_empty            (q_empty),
    .q_entry            (rd_entry),
    .pop                (pop),
    .out_ready          (out_ch.ready),
    .out_valid          (out_ch.valid),
    .out_filtered_speed (out_ch.filtered_speed),
    .out_sample_index   (out_ch.sample_index),
    .out_check_status   (out_ch.check_status),
    .out_window_failed  (out_ch.window_failed)
  );

endmodule

@@ test/tb_position_speed_median_check.sv @@
// Testbench for position_speed_median_check: predicted median speeds, register port and run checks.
`timescale 1ns / 1ps

module tb_position_speed_median_check;

  // Small index cap so that saturation is reached within a run.
  localparam int MAX_SAMPLES  = 160;
  localparam int IDX_CAP      = (MAX_SAMPLES - 1 > 8191) ? 8191 : MAX_SAMPLES - 1;
  localparam int SETTLE       = 16;
  localparam int LIMIT        = 200000;
  localparam int RANDOM_ITEMS = 1850;

  localparam logic [2:0] REG_NONE = 3'd7;
  localparam logic [2:0] REG_LIST [7] = '{psm_pkg::REG_SPEED_GAIN, psm_pkg::REG_WRAP_LIMIT,
                                          psm_pkg::REG_WRAP_HIGH_MARK, psm_pkg::REG_SPEED_MIN,
                                          psm_pkg::REG_SPEED_MAX, psm_pkg::REG_WINDOW_START,
                                          psm_pkg::REG_WINDOW_END};
  localparam string REG_NAMES [7] = '{"speed_gain", "wrap_limit", "wrap_high_mark",
                                      "speed_min", "speed_max", "window_start", "window_end"};

  // {start_of_run, position}: rails, upward and downward wraps, restart mid-run.
  localparam logic [16:0] WRAP_WALK [14] = '{
    {1'b1, 16'h0000}, {1'b0, 16'hFFFF}, {1'b0, 16'h0000}, {1'b0, 16'hFFFF},
    {1'b0, 16'd65000}, {1'b0, 16'd10}, {1'b0, 16'd20}, {1'b0, 16'd65500},
    {1'b1, 16'd1234}, {1'b0, 16'd1234}, {1'b0, 16'd3000}, {1'b0, 16'd5000},
    {1'b0, 16'd7000}, {1'b0, 16'd9000}};
  // Unit gain: medians inside, above and below the limits, both signs.
  localparam logic [15:0] LIMIT_WALK [11] = '{16'd50000, 16'd45000, 16'd40000, 16'd35000,
                                              16'd29000, 16'd23000, 16'd22900, 16'd22800,
                                              16'd27800, 16'd32800, 16'd37800};

  typedef enum {CFG_RESET, CFG_RAW, CFG_EXTREME, CFG_TRACK, CFG_CROSSED} cfg_style_t;

  typedef struct packed {
    logic signed [19:0] speed;
    logic [12:0]        index;
    logic [1:0]         status;
    logic               failed;
  } median_result_t;

  class median_scoreboard;
    psm_pkg::psm_cfg_t cfg;
    logic [15:0]       last_pos;
    int                hist [2];
    int unsigned       fill;
    int unsigned       run_idx;
    bit                fail_flag;
    median_result_t    due [$];
    int fails, results, in_window, too_high, too_low, saturated;

    function new();
      cfg.speed_gain     = psm_pkg::RST_SPEED_GAIN;
      cfg.wrap_limit     = psm_pkg::RST_WRAP_LIMIT;
      cfg.wrap_high_mark = psm_pkg::RST_WRAP_HIGH_MARK;
      cfg.speed_min      = psm_pkg::RST_SPEED_MIN;
      cfg.speed_max      = psm_pkg::RST_SPEED_MAX;
      cfg.window_start   = psm_pkg::RST_WINDOW_START;
      cfg.window_end     = psm_pkg::RST_WINDOW_END;
      last_pos  = '0;
      hist      = '{0, 0};
      fill      = 0;
      run_idx   = 0;
      fail_flag = 1'b0;
    endfunction

    function void set_reg(logic [2:0] idx, logic [31:0] value);
      case (idx)
        psm_pkg::REG_SPEED_GAIN:     cfg.speed_gain     = value[15:0];
        psm_pkg::REG_WRAP_LIMIT:     cfg.wrap_limit     = value[18:0];
        psm_pkg::REG_WRAP_HIGH_MARK: cfg.wrap_high_mark = value[15:0];
        psm_pkg::REG_SPEED_MIN:      cfg.speed_min      = value[18:0];
        psm_pkg::REG_SPEED_MAX:      cfg.speed_max      = value[18:0];
        psm_pkg::REG_WINDOW_START:   cfg.window_start   = value[12:0];
        psm_pkg::REG_WINDOW_END:     cfg.window_end     = value[12:0];
        default: ;
      endcase
    endfunction

    function logic [31:0] reg_value(logic [2:0] idx);
      case (idx)
        psm_pkg::REG_SPEED_GAIN:     return 32'(cfg.speed_gain);
        psm_pkg::REG_WRAP_LIMIT:     return 32'(cfg.wrap_limit);
        psm_pkg::REG_WRAP_HIGH_MARK: return 32'(cfg.wrap_high_mark);
        psm_pkg::REG_SPEED_MIN:      return 32'(cfg.speed_min);
        psm_pkg::REG_SPEED_MAX:      return 32'(cfg.speed_max);
        psm_pkg::REG_WINDOW_START:   return 32'(cfg.window_start);
        psm_pkg::REG_WINDOW_END:     return 32'(cfg.window_end);
        default:                     return '0;
      endcase
    endfunction

    // Signed division truncates toward zero.
    function longint scaled(longint delta);
      return (delta * longint'(cfg.speed_gain)) / 16384;
    endfunction

    function int rotor_speed(logic [15:0] older, logic [15:0] newer);
      longint s, m, w;
      s = scaled(longint'(newer) - longint'(older));
      m = (s < 0) ? -s : s;
      if (m > longint'(cfg.wrap_limit)) begin
        if (older > cfg.wrap_high_mark)
          w = longint'(newer) + (longint'(psm_pkg::WRAP_TOP) - longint'(older));
        else
          w = -((longint'(psm_pkg::WRAP_TOP) - longint'(newer)) + longint'(older));
        s = scaled(w);
      end
      return int'(-s);
    endfunction

    function int median3(int a, int b, int c);
      int lo, hi, m;
      lo = (a < b) ? a : b;
      hi = (a < b) ? b : a;
      m  = (hi < c) ? hi : c;
      return (lo > m) ? lo : m;
    endfunction

    function void note_sample(logic [15:0] pos, bit start);
      int             s, f;
      longint         mag;
      median_result_t r;
      if (start) begin
        hist      = '{0, 0};
        fill      = 0;
        run_idx   = 0;
        fail_flag = 1'b0;
      end
      if (fill == 0) begin
        last_pos = pos;
        fill     = 1;
        return;
      end
      s        = rotor_speed(last_pos, pos);
      last_pos = pos;
      if (fill >= 3) begin
        f        = median3(hist[0], hist[1], s);
        r.speed  = f[19:0];
        r.index  = run_idx[12:0];
        r.status = psm_pkg::ST_OUTSIDE;
        if (run_idx >= cfg.window_start && run_idx <= cfg.window_end) begin
          in_window++;
          mag = (f < 0) ? -longint'(f) : longint'(f);
          if (mag > longint'(cfg.speed_max)) begin
            r.status  = psm_pkg::ST_HIGH;
            fail_flag = 1'b1;
            too_high++;
          end else if (mag < longint'(cfg.speed_min)) begin
            r.status  = psm_pkg::ST_LOW;
            fail_flag = 1'b1;
            too_low++;
          end else begin
            r.status = psm_pkg::ST_OK;
          end
        end
        if (run_idx < IDX_CAP) run_idx++;
        else saturated++;
        r.failed = fail_flag;
        due.push_back(r);
      end else begin
        fill++;
      end
      hist[0] = hist[1];
      hist[1] = s;
    endfunction

    function void check_result(logic signed [19:0] speed, logic [12:0] index,
                               logic [1:0] status, logic failed);
      median_result_t want;
      if (due.size() == 0) begin
        $error("transfer with no result pending: filtered_speed %0d, sample_index %0d",
               speed, index);
        fails++;
        return;
      end
      want = due.pop_front();
      results++;
      if (speed !== want.speed) begin
        $error("filtered_speed: expected %0d, got %0d", $signed(want.speed), speed);
        fails++;
      end
      if (index !== want.index) begin
        $error("sample_index: expected %0d, got %0d", want.index, index);
        fails++;
      end
      if (status !== want.status) begin
        $error("check_status: expected %0d, got %0d", want.status, status);
        fails++;
      end
      if (failed !== want.failed) begin
        $error("window_failed: expected %0d, got %0d", want.failed, failed);
        fails++;
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n;
  logic        cfg_psel;
  logic        cfg_penable;
  logic        cfg_pwrite;
  logic [4:0]  cfg_paddr;
  logic [31:0] cfg_pwdata;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  psm_in_if  samples ();
  psm_out_if speeds ();

  median_scoreboard board;
  bit calm;
  int reg_fails;
  int sample_count;
  int runs;
  int settings;
  int cycles;

  position_speed_median_check #(.MAX_SAMPLES(MAX_SAMPLES)) dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (samples),
    .out_ch      (speeds),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  always #2 clk = ~clk;

  always @(posedge clk) begin
    if (rst_n && speeds.valid && speeds.ready)
      board.check_result(speeds.filtered_speed, speeds.sample_index,
                         speeds.check_status, speeds.window_failed);
  end

  // Result side: stall a random number of cycles before each transfer.
  initial begin
    int stall;
    speeds.ready <= 1'b0;
    @(posedge clk);
    forever begin
      stall = calm ? 0 : $urandom_range(0, 3);
      if (stall != 0) begin
        speeds.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      speeds.ready <= 1'b1;
      @(posedge clk);
      while (!speeds.valid) @(posedge clk);
    end
  end

  initial begin
    cycles = 0;
    while (cycles < LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("run stopped at the cycle limit of %0d", LIMIT);
    $display("** position_speed_median_check: FAILED **");
    $finish;
  end

  task automatic push_sample(logic [15:0] pos, bit start);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 3);
    repeat (gap) begin
      samples.valid <= 1'b0;
      @(posedge clk);
    end
    samples.valid        <= 1'b1;
    samples.position     <= pos;
    samples.start_of_run <= start;
    @(posedge clk);
    while (!samples.ready) @(posedge clk);
    board.note_sample(pos, start);
    sample_count++;
    if (start) runs++;
  endtask

  task automatic reg_write(logic [2:0] idx, logic [31:0] value);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    board.set_reg(idx, value);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic reg_readback(int slot);
    logic [31:0] want;
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    cfg_paddr   <= {REG_LIST[slot], 2'b00};
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    want = board.reg_value(REG_LIST[slot]);
    if (cfg_prdata !== want) begin
      $error("%s: expected %0d, got %0d", REG_NAMES[slot], want, cfg_prdata);
      reg_fails++;
    end
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    @(posedge clk);
  endtask

  // Drain every pending result, then let samples that give none leave the pipeline.
  task automatic settle();
    samples.valid <= 1'b0;
    @(posedge clk);
    while (board.due.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic program_regs(cfg_style_t style, int base_step);
    logic [31:0] val [7];
    logic [31:0] held;
    int          gain, mag;
    case (style)
      CFG_RESET: begin
        val[psm_pkg::REG_SPEED_GAIN]     = 32'(psm_pkg::RST_SPEED_GAIN);
        val[psm_pkg::REG_WRAP_LIMIT]     = 32'(psm_pkg::RST_WRAP_LIMIT);
        val[psm_pkg::REG_WRAP_HIGH_MARK] = 32'(psm_pkg::RST_WRAP_HIGH_MARK);
        val[psm_pkg::REG_SPEED_MIN]      = 32'(psm_pkg::RST_SPEED_MIN);
        val[psm_pkg::REG_SPEED_MAX]      = 32'(psm_pkg::RST_SPEED_MAX);
        val[psm_pkg::REG_WINDOW_START]   = 32'(psm_pkg::RST_WINDOW_START);
        val[psm_pkg::REG_WINDOW_END]     = 32'(psm_pkg::RST_WINDOW_END);
      end
      CFG_RAW: begin
        foreach (val[i]) val[i] = $urandom();
      end
      CFG_EXTREME: begin
        foreach (val[i]) val[i] = $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0;
      end
      default: begin
        // Center the limits on the speed that the run's step produces.
        gain = $urandom_range(4096, 40000);
        mag  = ((base_step < 0 ? -base_step : base_step) * gain) / 16384;
        val[psm_pkg::REG_SPEED_GAIN]     = gain;
        val[psm_pkg::REG_WRAP_LIMIT]     = 2 * mag + 50;
        val[psm_pkg::REG_WRAP_HIGH_MARK] = $urandom_range(55000, 65535);
        val[psm_pkg::REG_SPEED_MIN]      = mag - mag / 8;
        val[psm_pkg::REG_SPEED_MAX]      = mag + mag / 8;
        val[psm_pkg::REG_WINDOW_START]   = $urandom_range(0, IDX_CAP);
        val[psm_pkg::REG_WINDOW_END]     = val[psm_pkg::REG_WINDOW_START] +
                                           $urandom_range(0, 60);
        if (style == CFG_CROSSED) begin
          if ($urandom_range(0, 1)) begin
            held                          = val[psm_pkg::REG_SPEED_MIN];
            val[psm_pkg::REG_SPEED_MIN]   = val[psm_pkg::REG_SPEED_MAX] + 1;
            val[psm_pkg::REG_SPEED_MAX]   = held;
          end else begin
            held                           = val[psm_pkg::REG_WINDOW_START];
            val[psm_pkg::REG_WINDOW_START] = val[psm_pkg::REG_WINDOW_END] + 1;
            val[psm_pkg::REG_WINDOW_END]   = held;
          end
        end
      end
    endcase
    foreach (REG_LIST[i]) reg_write(REG_LIST[i], val[REG_LIST[i]]);
    if ($urandom_range(0, 2) == 0) reg_write(REG_NONE, $urandom());
    foreach (REG_LIST[i]) reg_readback(i);
    settings++;
  endtask

  task automatic drive_run(int len, int base_step, bit fresh);
    logic [15:0] pos;
    int          jit, wobble;
    pos    = 16'($urandom());
    wobble = (base_step < 0 ? -base_step : base_step) / 16 + 1;
    for (int k = 0; k < len; k++) begin
      if (k != 0) begin
        jit = int'($urandom_range(0, 2 * wobble)) - wobble;
        case ($urandom_range(0, 19))
          0:       pos = 16'($urandom());
          // spike for the median to reject
          1:       pos = 16'(int'(pos) + 3 * base_step);
          default: pos = 16'(int'(pos) + base_step + jit);
        endcase
      end
      push_sample(pos, (k == 0) ? fresh : ($urandom_range(0, 63) == 0));
    end
  endtask

  initial begin
    int         target, base_step, len, pick;
    cfg_style_t style;
    board                = new();
    calm                 = 1'b0;
    rst_n               <= 1'b0;
    samples.valid       <= 1'b0;
    samples.position    <= '0;
    samples.start_of_run <= 1'b0;
    cfg_psel            <= 1'b0;
    cfg_penable         <= 1'b0;
    cfg_pwrite          <= 1'b0;
    cfg_paddr           <= '0;
    cfg_pwdata          <= '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (REG_LIST[i]) reg_readback(i);
    settings = 1;
    foreach (WRAP_WALK[i]) push_sample(WRAP_WALK[i][15:0], WRAP_WALK[i][16]);

    settle();
    reg_write(psm_pkg::REG_SPEED_GAIN, 32'd16384);
    reg_write(psm_pkg::REG_WINDOW_START, 32'd0);
    reg_write(psm_pkg::REG_WINDOW_END, 32'd8191);
    settings++;
    foreach (LIMIT_WALK[i]) push_sample(LIMIT_WALK[i], i == 0);

    target = sample_count + RANDOM_ITEMS;
    while (sample_count < target) begin
      if ($urandom_range(0, 4) == 0)
        base_step = int'($urandom_range(0, 65535)) - 32768;
      else if ($urandom_range(0, 1))
        base_step = $urandom_range(1, 4000);
      else
        base_step = -int'($urandom_range(1, 4000));
      pick = $urandom_range(0, 9);
      case (pick)
        0:       style = CFG_RESET;
        1:       style = CFG_RAW;
        2:       style = CFG_EXTREME;
        8, 9:    style = CFG_CROSSED;
        default: style = CFG_TRACK;
      endcase
      settle();
      calm = 1'b0;
      program_regs(style, base_step);
      calm = ($urandom_range(0, 3) == 0);
      repeat ($urandom_range(2, 5)) begin
        len = ($urandom_range(0, 15) == 0) ? IDX_CAP + 12 : $urandom_range(1, 40);
        drive_run(len, base_step, $urandom_range(0, 7) != 0);
      end
    end
    settle();

    $display("%0d samples in %0d runs under %0d register settings gave %0d medians",
             sample_count, runs, settings, board.results);
    $display("%0d checked in the window (%0d too high, %0d too low), %0d at the index cap",
             board.in_window, board.too_high, board.too_low, board.saturated);
    if (board.fails == 0 && reg_fails == 0) begin
      $display("** position_speed_median_check: PASSED **");
    end else begin
      $display("** position_speed_median_check: FAILED **");
    end
    $finish;
  end

endmodule

@@ files.f @@
rtl/psm_pkg.sv
rtl/psm_chan_if.sv
rtl/psm_cfg.sv
rtl/psm_front.sv
rtl/psm_queue.sv
rtl/psm_back.sv
rtl/position_speed_median_check.sv
test/tb_position_speed_median_check.sv
